FILE: design/button_debounce_click_counter_defines.svh
// Assertion macros used by the checker file.
`ifndef BUTTON_DEBOUNCE_CLICK_COUNTER_DEFINES_SVH
`define BUTTON_DEBOUNCE_CLICK_COUNTER_DEFINES_SVH

// Same-cycle implication, disabled while rst is high.
`define BDCC_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// Next-cycle implication, disabled while rst is high.
`define BDCC_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

FILE: design/bdcc_pkg.sv
// Types, constants and register codes for the button debounce click counter.
package bdcc_pkg;

   localparam int TICK_WIDTH_DEFAULT = 32;
   localparam int QUEUE_DEPTH        = 2;

   localparam int NOW_W         = 32;
   localparam int TICK_MS_W     = 10;
   localparam int DEBOUNCE_MS_W = 10;
   localparam int DEB_TICKS_W   = 10;
   localparam int GAP_TICKS_W   = 16;
   localparam int LONG_MS_W     = 16;
   localparam int COUNT_W       = 8;
   localparam int DUR_W         = 32;
   localparam int CSR_INDEX_W   = 3;
   localparam int CSR_DATA_W    = 16;

   localparam logic [COUNT_W-1:0] COUNT_MAX = 8'hFF;
   localparam logic [DUR_W-1:0]   DUR_MAX   = 32'hFFFF_FFFF;

   localparam logic [TICK_MS_W-1:0]     TICK_MS_RST     = 10'd1;
   localparam logic [DEBOUNCE_MS_W-1:0] DEBOUNCE_MS_RST = 10'd20;
   localparam logic [DEB_TICKS_W-1:0]   DEB_TICKS_RST   = 10'd20;
   localparam logic [GAP_TICKS_W-1:0]   GAP_TICKS_RST   = 16'd500;
   localparam logic [LONG_MS_W-1:0]     LONG_MS_RST     = 16'd3000;

   typedef enum logic [CSR_INDEX_W-1:0] {
      REG_TICK_MS        = 3'd0,
      REG_DEBOUNCE_MS    = 3'd1,
      REG_DEBOUNCE_TICKS = 3'd2,
      REG_GAP_TICKS      = 3'd3,
      REG_LONG_MS        = 3'd4
   } reg_index_type;

   typedef struct packed {
      logic [TICK_MS_W-1:0]     tick_ms;
      logic [DEBOUNCE_MS_W-1:0] debounce_ms;
      logic [DEB_TICKS_W-1:0]   debounce_ticks;
      logic [GAP_TICKS_W-1:0]   gap_ticks;
      logic [LONG_MS_W-1:0]     long_ms;
   } cfg_type;

   typedef struct packed {
      logic [NOW_W-1:0] now_tick;
      logic             edge_seen;
   } poll_type;

   typedef struct packed {
      logic [DUR_W-1:0]   duration_ms;
      logic [COUNT_W-1:0] press_count;
   } result_type;

endpackage

FILE: design/button_debounce_click_counter.sv
// Button debounce click counter: one poll per transfer in, one report per finished burst out.
// Each req transfer is one poll of the button; the block takes one poll per clock cycle
// sustained while no report waits on rsp. The poll that ends a burst is registered in the
// intake queue, then the engine step forms its report in the result register on rsp. The
// engine step is combinational: a multiply of the hold span by tick_ms, an add, a
// saturating compare and the state update. A two-entry queue parts intake from the engine,
// and the engine stalls while a report waits on rsp. csr writes are taken every cycle
// and should only be issued while no poll is in flight. No clearing pass after reset.
module button_debounce_click_counter
   import bdcc_pkg::*;
#(
   parameter int TICK_WIDTH = TICK_WIDTH_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [31:0]            req_tdata,   // [31:0] now_tick
   input  logic [0:0]             req_tuser,   // [0] edge_seen
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [39:0]            rsp_tdata,   // [7:0] press_count, [39:8] duration_ms
   input  logic                   csr_tvalid,
   output logic                   csr_tready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   cfg_type    cfg;
   logic       head_valid;
   poll_type   head;
   logic       head_pop;
   result_type rsp_result;

   bdcc_csr u_csr (
      .clock      (clock),
      .reset      (reset),
      .csr_tvalid (csr_tvalid),
      .csr_tready (csr_tready),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .cfg        (cfg)
   );

   bdcc_front u_front (
      .clock         (clock),
      .reset         (reset),
      .req_tvalid    (req_tvalid),
      .req_tready    (req_tready),
      .req_now_tick  (req_tdata[NOW_W-1:0]),
      .req_edge_seen (req_tuser[0]),
      .head_valid    (head_valid),
      .head          (head),
      .head_pop      (head_pop)
   );

   bdcc_back #(
      .TICK_WIDTH (TICK_WIDTH)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .head_valid (head_valid),
      .head       (head),
      .head_pop   (head_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_result (rsp_result)
   );

   assign rsp_tdata = {rsp_result.duration_ms, rsp_result.press_count};

endmodule

FILE: design/bdcc_csr.sv
// Configuration registers written through the csr channel.
module bdcc_csr
   import bdcc_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_tvalid,
   output logic                   csr_tready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata,
   output cfg_type                cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   assign csr_tready = 1'b1;
   assign cfg        = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_tvalid) begin
         case (csr_index)
            REG_TICK_MS:        cfg_in.tick_ms        = csr_wdata[TICK_MS_W-1:0];
            REG_DEBOUNCE_MS:    cfg_in.debounce_ms    = csr_wdata[DEBOUNCE_MS_W-1:0];
            REG_DEBOUNCE_TICKS: cfg_in.debounce_ticks = csr_wdata[DEB_TICKS_W-1:0];
            REG_GAP_TICKS:      cfg_in.gap_ticks      = csr_wdata[GAP_TICKS_W-1:0];
            REG_LONG_MS:        cfg_in.long_ms        = csr_wdata[LONG_MS_W-1:0];
            default:            cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.tick_ms        <= TICK_MS_RST;
         cfg_ff.debounce_ms    <= DEBOUNCE_MS_RST;
         cfg_ff.debounce_ticks <= DEB_TICKS_RST;
         cfg_ff.gap_ticks      <= GAP_TICKS_RST;
         cfg_ff.long_ms        <= LONG_MS_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

FILE: design/bdcc_front.sv
// Poll intake: accepts transfers and queues them for the engine.
module bdcc_front
   import bdcc_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   output logic             req_tready,
   input  logic [NOW_W-1:0] req_now_tick,
   input  logic             req_edge_seen,
   output logic             head_valid,
   output poll_type         head,
   input  logic             head_pop
);

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);

   poll_type         entry_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             push;
   logic             pop;

   assign req_tready = (count_ff != CNT_FULL);
   assign head_valid = (count_ff != '0);
   assign head       = entry_ff[rd_ptr_ff];
   assign push       = req_tvalid && req_tready;
   assign pop        = head_pop && head_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff].now_tick  <= req_now_tick;
         entry_ff[wr_ptr_ff].edge_seen <= req_edge_seen;
      end
   end

endmodule

FILE: design/bdcc_back.sv
// Debounce, press counting and burst reporting engine with output register.
module bdcc_back
   import bdcc_pkg::*;
#(
   parameter int TICK_WIDTH = TICK_WIDTH_DEFAULT
) (
   input  logic       clock,
   input  logic       reset,
   input  cfg_type    cfg,
   input  logic       head_valid,
   input  poll_type   head,
   output logic       head_pop,
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output result_type rsp_result
);

   localparam int EXT_W  = TICK_WIDTH + NOW_W;
   localparam int PROD_W = (TICK_WIDTH + TICK_MS_W + 1 > DUR_W + 1) ?
                           TICK_WIDTH + TICK_MS_W + 1 : DUR_W + 1;

   logic                  edge_pending_ff, edge_pending_in;
   logic [TICK_WIDTH-1:0] idle_stamp_ff, idle_stamp_in;
   logic                  held_ff, held_in;
   logic                  ignore_ff, ignore_in;
   logic [COUNT_W-1:0]    count_ff, count_in;
   logic [TICK_WIDTH-1:0] press_start_ff, press_start_in;
   logic [TICK_WIDTH-1:0] last_stamp_ff, last_stamp_in;
   logic [DUR_W-1:0]      last_dur_ff, last_dur_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   result_type            rsp_data_ff, rsp_data_in;

   logic [EXT_W-1:0]      now_ext;
   logic [TICK_WIDTH-1:0] now;
   logic                  pending;
   logic [TICK_WIDTH-1:0] span_idle;
   logic [TICK_WIDTH-1:0] span_press;
   logic [TICK_WIDTH-1:0] span_last;
   logic [PROD_W-1:0]     prod;
   logic [DUR_W-1:0]      dur_hold;
   logic [DUR_W-1:0]      dur_check;
   logic                  started;
   logic                  emit;
   logic                  step;

   assign step       = head_valid && (!rsp_valid_ff || rsp_tready);
   assign head_pop   = step;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_result = rsp_data_ff;

   assign now_ext    = {{TICK_WIDTH{1'b0}}, head.now_tick};
   assign now        = now_ext[TICK_WIDTH-1:0];
   assign pending    = edge_pending_ff || head.edge_seen;
   assign span_idle  = now - idle_stamp_ff;
   assign span_press = now - press_start_ff;
   assign prod       = PROD_W'(span_press) * PROD_W'(cfg.tick_ms)
                       + PROD_W'(cfg.debounce_ms);
   assign dur_hold   = (prod > PROD_W'(DUR_MAX)) ? DUR_MAX : prod[DUR_W-1:0];

   always_comb begin
      edge_pending_in = pending;
      idle_stamp_in   = idle_stamp_ff;
      held_in         = held_ff;
      ignore_in       = ignore_ff;
      count_in        = count_ff;
      press_start_in  = press_start_ff;
      last_stamp_in   = last_stamp_ff;
      last_dur_in     = last_dur_ff;
      started         = 1'b0;
      emit            = 1'b0;
      dur_check       = dur_hold;
      span_last       = '0;

      if (pending) begin
         if (PROD_W'(span_idle) > PROD_W'(cfg.debounce_ticks)) begin
            edge_pending_in = 1'b0;
            idle_stamp_in   = now;
            if (held_ff) begin
               held_in = 1'b0;
               if (ignore_ff) begin
                  ignore_in = 1'b0;
               end else begin
                  count_in      = (count_ff != COUNT_MAX) ? count_ff + 1'b1 : count_ff;
                  last_dur_in   = dur_hold;
                  last_stamp_in = now;
               end
            end else begin
               press_start_in = now;
               held_in        = 1'b1;
               started        = 1'b1;
            end
         end
      end else begin
         idle_stamp_in = now;
      end

      if (started) begin
         dur_check = DUR_W'(cfg.debounce_ms);
      end

      if (!ignore_in && held_in && (dur_check > DUR_W'(cfg.long_ms))) begin
         idle_stamp_in = now;
         ignore_in     = 1'b1;
         count_in      = (count_in != COUNT_MAX) ? count_in + 1'b1 : count_in;
         last_dur_in   = dur_check;
         last_stamp_in = now;
      end

      span_last = now - last_stamp_in;
      if ((count_in != '0) && (PROD_W'(span_last) >= PROD_W'(cfg.gap_ticks))) begin
         emit = 1'b1;
      end

      rsp_data_in.press_count = count_in;
      rsp_data_in.duration_ms = last_dur_in;
      if (emit) begin
         count_in = '0;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (step) begin
         rsp_valid_in = emit;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         edge_pending_ff <= 1'b0;
         idle_stamp_ff   <= '0;
         held_ff         <= 1'b0;
         ignore_ff       <= 1'b0;
         count_ff        <= '0;
         press_start_ff  <= '0;
         last_stamp_ff   <= '0;
         last_dur_ff     <= '0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (step) begin
            edge_pending_ff <= edge_pending_in;
            idle_stamp_ff   <= idle_stamp_in;
            held_ff         <= held_in;
            ignore_ff       <= ignore_in;
            count_ff        <= count_in;
            press_start_ff  <= press_start_in;
            last_stamp_ff   <= last_stamp_in;
            last_dur_ff     <= last_dur_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (step && emit) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

endmodule

FILE: design/bdcc_checker.sv
// Port-level checks for the button debounce click counter, bound to the top level.
`include "button_debounce_click_counter_defines.svh"

module bdcc_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [39:0] rsp_tdata
);

   `BDCC_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata))
   `BDCC_ASSERT_IMPL(a_count_nonzero, clock, reset, rsp_tvalid, rsp_tdata[7:0] != 8'd0)
   `BDCC_ASSERT_NEXT(a_reset_no_rsp, clock, 1'b0, reset, !rsp_tvalid)
   `BDCC_ASSERT_NEXT(a_reset_ready, clock, 1'b0, reset, req_tready)

endmodule

bind button_debounce_click_counter bdcc_checker u_bdcc_checker (.*);
